[design/sfd_pkg.sv]
package sfd_pkg;

	localparam int BYTE_W    = 8;
	localparam int CLASS_W   = 2;
	localparam int READING_W = 32;
	localparam int CFG_IDX_W = 3;

	// sync word 55 AA 55 AA
	localparam logic [BYTE_W-1:0] SYNC_A = 8'h55;
	localparam logic [BYTE_W-1:0] SYNC_B = 8'hAA;
	localparam int SYNC_LEN = 4;
	localparam int BODY_LEN = 7;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OXYGEN      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PH          = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TEMPERATURE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TURBIDITY   = 3'd4;

	// class indexes
	localparam logic [CLASS_W-1:0] CLASS_OXYGEN      = 2'd0;
	localparam logic [CLASS_W-1:0] CLASS_PH          = 2'd1;
	localparam logic [CLASS_W-1:0] CLASS_TEMPERATURE = 2'd2;
	localparam logic [CLASS_W-1:0] CLASS_TURBIDITY   = 2'd3;

	typedef struct packed {
		logic [BYTE_W-1:0] oxygen;
		logic [BYTE_W-1:0] ph;
		logic [BYTE_W-1:0] temperature;
		logic [BYTE_W-1:0] turbidity;
	} type_codes_t;

	typedef struct packed {
		logic [CLASS_W-1:0]   sensor_class;
		logic                 type_unknown;
		logic [BYTE_W-1:0]    type_byte;
		logic [BYTE_W-1:0]    install_location;
		logic [BYTE_W-1:0]    device_number;
		logic [READING_W-1:0] reading_bits;
	} frame_result_t;

endpackage

[design/sfd_parser.sv]
module sfd_parser
	import sfd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [BYTE_W-1:0] rx_byte,
	input  type_codes_t       codes,
	output logic              res_valid,
	output frame_result_t     res
);

	localparam int BODY_STORE = BODY_LEN - 1;
	localparam logic [2:0] BODY_LAST = 3'(BODY_LEN - 1);

	logic [1:0]        sync_matched_q;
	logic              in_body_q;
	logic [2:0]        body_count_q;
	logic [BYTE_W-1:0] body_q [BODY_STORE];
	logic [CLASS_W-1:0] last_class_q;

	logic [2:0]         hunt_nx;
	logic [CLASS_W-1:0] cls;
	logic               unknown;
	logic               body_last;

	// sliding match of 55 AA 55 AA; a value of SYNC_LEN means found
	always_comb begin
		unique case (sync_matched_q)
			2'd0: hunt_nx = (rx_byte == SYNC_A) ? 3'd1 : 3'd0;
			2'd1: hunt_nx = (rx_byte == SYNC_B) ? 3'd2 : ((rx_byte == SYNC_A) ? 3'd1 : 3'd0);
			2'd2: hunt_nx = (rx_byte == SYNC_A) ? 3'd3 : 3'd0;
			2'd3: hunt_nx = (rx_byte == SYNC_B) ? 3'(SYNC_LEN)
			                : ((rx_byte == SYNC_A) ? 3'd1 : 3'd0);
			default: hunt_nx = 3'd0;
		endcase
	end

	// lowest matching class wins
	always_comb begin
		unknown = 1'b0;
		priority if (body_q[0] == codes.oxygen)      cls = CLASS_OXYGEN;
		else if (body_q[0] == codes.ph)              cls = CLASS_PH;
		else if (body_q[0] == codes.temperature)     cls = CLASS_TEMPERATURE;
		else if (body_q[0] == codes.turbidity)       cls = CLASS_TURBIDITY;
		else begin
			cls     = last_class_q;
			unknown = 1'b1;
		end
	end

	assign body_last = in_body_q && (body_count_q == BODY_LAST);
	assign res_valid = step && body_last;

	always_comb begin
		res.sensor_class     = cls;
		res.type_unknown     = unknown;
		res.type_byte        = body_q[0];
		res.install_location = body_q[1];
		res.device_number    = body_q[2];
		res.reading_bits     = {rx_byte, body_q[5], body_q[4], body_q[3]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_matched_q <= '0;
			in_body_q      <= 1'b0;
			body_count_q   <= '0;
			last_class_q   <= CLASS_OXYGEN;
		end else if (step) begin
			if (!in_body_q) begin
				if (hunt_nx == 3'(SYNC_LEN)) begin
					sync_matched_q <= '0;
					in_body_q      <= 1'b1;
					body_count_q   <= '0;
				end else begin
					sync_matched_q <= hunt_nx[1:0];
				end
			end else if (body_last) begin
				in_body_q      <= 1'b0;
				body_count_q   <= '0;
				sync_matched_q <= '0;
				last_class_q   <= cls;
			end else begin
				body_count_q <= body_count_q + 3'd1;
			end
		end
	end

	// body store: no reset, every byte is written before the frame reads it
	always_ff @(posedge clk) begin
		if (step && in_body_q && !body_last) begin
			body_q[body_count_q] <= rx_byte;
		end
	end

endmodule

[design/sensor_frame_deframer_top.sv]
// Sensor frame deframer. Takes one received byte per request on the input
// channel, hunts for the sync word 55 AA 55 AA (sliding one byte at a time),
// then captures a 7-byte body: type code, install location, device number and
// a little-endian 32-bit reading. The seventh body byte yields one result
// request; the type code is matched against four configured codes (lowest
// class wins on equal codes); an unknown code raises type_unknown and reports
// the previous class. Each byte is handled in the cycle it is accepted, so the
// block takes one byte per clock when not stalled; results go through an
// output register backed by a one-entry skid register, and in_stall rises
// only while that skid entry is occupied. Write configuration only while idle;
// with enable low, bytes are accepted and dropped and parser state holds.
module sensor_frame_deframer_top
	import sfd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [BYTE_W-1:0]    rx_byte,

	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [CLASS_W-1:0]   sensor_class,
	output logic                 type_unknown,
	output logic [BYTE_W-1:0]    type_byte,
	output logic [BYTE_W-1:0]    install_location,
	output logic [BYTE_W-1:0]    device_number,
	output logic [READING_W-1:0] reading_bits,

	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data
);

	logic          enable_q;
	type_codes_t   codes_q;

	logic          in_accept;
	logic          step;
	logic          res_valid;
	frame_result_t res;

	logic          out_valid_q;
	frame_result_t out_q;
	logic          skid_valid_q;
	frame_result_t skid_q;
	logic          out_take;

	// configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q            <= 1'b0;
			codes_q.oxygen      <= 8'd0;
			codes_q.ph          <= 8'd1;
			codes_q.temperature <= 8'd2;
			codes_q.turbidity   <= 8'd3;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ENABLE:      enable_q            <= cfg_data[0];
				CFG_OXYGEN:      codes_q.oxygen      <= cfg_data;
				CFG_PH:          codes_q.ph          <= cfg_data;
				CFG_TEMPERATURE: codes_q.temperature <= cfg_data;
				CFG_TURBIDITY:   codes_q.turbidity   <= cfg_data;
				default: ;   // unknown index: drop the write
			endcase
		end
	end

	// stall only while the skid entry holds a result; then there is always a
	// free slot for a result made by the accepted byte
	assign in_stall  = skid_valid_q;
	assign in_accept = in_valid && !in_stall;
	assign step      = in_accept && enable_q;

	sfd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.rx_byte   (rx_byte),
		.codes     (codes_q),
		.res_valid (res_valid),
		.res       (res)
	);

	assign out_take = out_valid_q && !out_stall;

	// output register with skid: advance skid into output when taken, park a
	// new result in skid when the output is held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (res_valid) begin
			if (!out_valid_q || out_take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_q <= skid_q;
			end
		end else if (res_valid) begin
			if (!out_valid_q || out_take) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign sensor_class     = out_q.sensor_class;
	assign type_unknown     = out_q.type_unknown;
	assign type_byte        = out_q.type_byte;
	assign install_location = out_q.install_location;
	assign device_number    = out_q.device_number;
	assign reading_bits     = out_q.reading_bits;

endmodule

[design/sfd_checker.sv]
module sfd_checker
	import sfd_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [CLASS_W-1:0]   sensor_class,
	input logic                 type_unknown,
	input logic [BYTE_W-1:0]    type_byte,
	input logic [BYTE_W-1:0]    install_location,
	input logic [BYTE_W-1:0]    device_number,
	input logic [READING_W-1:0] reading_bits
);

	// a held result stays valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a held result keeps all of its fields
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable({sensor_class, type_unknown, type_byte,
			install_location, device_number, reading_bits}))
		else $error("result changed while stalled");

	// a new result only follows an accepted byte
	a_res_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall))
		else $error("result without accepted byte");

	// input stalls only while a result waits at the output
	a_stall_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("stall without waiting result");

	// taking the output frees the input next cycle
	a_stall_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall && !out_stall |=> !in_stall)
		else $error("stall held after output taken");

endmodule

bind sensor_frame_deframer_top sfd_checker u_sfd_checker (.*);
